FILE: src/bfd_pkg.sv
// Shared types and constants for the box filter downsampler.
// No dependencies; imported by bfd_position and box_filter_downsampler.
`default_nettype none

package bfd_pkg;

  localparam int unsigned MaxOutWidth   = 1024;
  localparam int unsigned MaxFactorLog2 = 3;
  localparam int unsigned HeightLimit   = 4096;

  localparam int unsigned ColW     = $clog2(MaxOutWidth);
  localparam int unsigned WidthW   = 11;
  localparam int unsigned HeightW  = 13;
  localparam int unsigned RowW     = $clog2(HeightLimit);
  localparam int unsigned SubW     = MaxFactorLog2;
  localparam int unsigned FactorW  = 2;
  localparam int unsigned ChanW    = 8;
  localparam int unsigned NumChan  = 4;
  localparam int unsigned PixW     = ChanW * NumChan;
  // A full 8x8 block of 255 needs 14 bits per channel.
  localparam int unsigned SumW     = ChanW + 2 * MaxFactorLog2;
  localparam int unsigned SumTotW  = SumW * NumChan;
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 13;

  typedef enum logic [CfgAddrW-1:0] {
    CfgOutWidth   = 2'd0,
    CfgOutHeight  = 2'd1,
    CfgFactorLog2 = 2'd2
  } cfg_idx_e;

  // Per-pixel position information handed from the position tracker.
  typedef struct packed {
    logic [ColW-1:0] col;
    logic            block_start;
    logic            emit;
    logic            row_end;
    logic            frame_end;
  } pos_t;

endpackage

`default_nettype wire

FILE: src/bfd_position.sv
// Raster position tracker for the box filter downsampler.
// Depends on bfd_pkg for widths and the pos_t struct.
`default_nettype none

module bfd_position (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  logic                        frame_start_i,
  input  logic [bfd_pkg::WidthW-1:0]  out_width_i,
  input  logic [bfd_pkg::HeightW-1:0] out_height_i,
  input  logic [bfd_pkg::FactorW-1:0] factor_log2_i,
  output bfd_pkg::pos_t               pos_o
);
  import bfd_pkg::*;

  logic [SubW-1:0]    sub_col_q, sub_col_d, sub_row_q, sub_row_d;
  logic [ColW-1:0]    out_col_q, out_col_d;
  logic [RowW-1:0]    out_row_q, out_row_d;
  logic [WidthW-1:0]  width;
  logic [HeightW-1:0] height;
  logic [SubW-1:0]    f_last;
  logic [SubW-1:0]    sc, sr;
  logic [ColW-1:0]    oc;
  logic [RowW-1:0]    orow;
  logic               sc_end, sr_end, col_last, row_last;

  // Clamp the geometry registers into their legal ranges. The factor field
  // is two bits wide, so it can never exceed the largest supported factor.
  always_comb begin
    if (out_width_i == '0) begin
      width = WidthW'(1);
    end else if (out_width_i > WidthW'(MaxOutWidth)) begin
      width = WidthW'(MaxOutWidth);
    end else begin
      width = out_width_i;
    end
    if (out_height_i == '0) begin
      height = HeightW'(1);
    end else if (out_height_i > HeightW'(HeightLimit)) begin
      height = HeightW'(HeightLimit);
    end else begin
      height = out_height_i;
    end
  end

  assign f_last = ~({SubW{1'b1}} << factor_log2_i);

  // Counters at or beyond their limits restart at zero, as does a frame start.
  assign sc   = (frame_start_i || sub_col_q > f_last) ? '0 : sub_col_q;
  assign sr   = (frame_start_i || sub_row_q > f_last) ? '0 : sub_row_q;
  assign oc   = (frame_start_i || {1'b0, out_col_q} >= width) ? '0 : out_col_q;
  assign orow = (frame_start_i || {1'b0, out_row_q} >= height) ? '0 : out_row_q;

  assign sc_end   = (sc == f_last);
  assign sr_end   = (sr == f_last);
  assign col_last = (({1'b0, oc} + WidthW'(1)) == width);
  assign row_last = (({1'b0, orow} + HeightW'(1)) == height);

  always_comb begin
    sub_col_d = sc_end ? '0 : sc + SubW'(1);
    out_col_d = oc;
    sub_row_d = sr;
    out_row_d = orow;
    if (sc_end) begin
      out_col_d = col_last ? '0 : oc + ColW'(1);
      if (col_last) begin
        sub_row_d = sr_end ? '0 : sr + SubW'(1);
        if (sr_end) begin
          out_row_d = row_last ? '0 : orow + RowW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_col_q <= '0;
      sub_row_q <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else if (adv_i) begin
      sub_col_q <= sub_col_d;
      sub_row_q <= sub_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
    end
  end

  assign pos_o.col         = oc;
  assign pos_o.block_start = (sc == '0) && (sr == '0);
  assign pos_o.emit        = sc_end && sr_end;
  assign pos_o.row_end     = col_last;
  assign pos_o.frame_end   = col_last && row_last;

endmodule

`default_nettype wire

FILE: src/box_filter_downsampler.sv
// Box filter downsampler top level: accepts 32-bit pixels, emits FxF block means.
// Depends on bfd_pkg and bfd_position.
// A pixel that completes a block passes stage one and then the output register
// before it shows up on the master side; one pixel is taken every cycle while the
// input is not stalled. The only stall is a full output register that the
// downstream side does not take. Reset clears the position counters, pipeline
// valid bits and the geometry registers (640x480, factor 4), not the sum memory.
`default_nettype none

module box_filter_downsampler (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Slave stream: tdata = subpixel[31:0]; tuser = frame_start.
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [bfd_pkg::PixW-1:0]     s_axis_tdata,
  input  logic                         s_axis_tuser,
  // Master stream: tdata = average_pixel[31:0]; tlast = row_end;
  // tuser = frame_end.
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [bfd_pkg::PixW-1:0]     m_axis_tdata,
  output logic                         m_axis_tlast,
  output logic                         m_axis_tuser,
  // Configuration write channel.
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [bfd_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [bfd_pkg::CfgDataW-1:0] cfg_data_i
);
  import bfd_pkg::*;

  // Geometry registers.
  logic [WidthW-1:0]  out_width_q;
  logic [HeightW-1:0] out_height_q;
  logic [FactorW-1:0] factor_log2_q;

  // Stage one: the accepted pixel together with its column's stored sums.
  logic               s1_valid_q;
  logic [PixW-1:0]    s1_pix_q;
  pos_t               s1_pos_q;
  logic [FactorW-1:0] s1_k_q;
  logic [SumTotW-1:0] rd_q;
  logic               fwd_hit_q;
  logic [SumTotW-1:0] fwd_sum_q;

  // Output register.
  logic               out_valid_q;
  logic [PixW-1:0]    out_pix_q;
  logic               out_row_end_q;
  logic               out_frame_end_q;

  logic               in_acc, out_free, s1_adv;
  pos_t               pos;
  logic [SumTotW-1:0] old_sum, new_sum;
  logic [PixW-1:0]    avg;

  // Column sums: four 14-bit channel sums per output column.
  logic [SumTotW-1:0] sum_mem [MaxOutWidth];

  // ---------------------------------------------------------------------------
  // Configuration. Writes must arrive only while the block is idle; the block
  // does not enforce it. The channel is always ready; other indexes are dropped.
  // ---------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_width_q   <= WidthW'(640);
      out_height_q  <= HeightW'(480);
      factor_log2_q <= FactorW'(2);
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_addr_i))
        CfgOutWidth:   out_width_q   <= cfg_data_i[WidthW-1:0];
        CfgOutHeight:  out_height_q  <= cfg_data_i[HeightW-1:0];
        CfgFactorLog2: factor_log2_q <= cfg_data_i[FactorW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake. Stage one drains into the output register unless it holds a
  // finished block and the output register is still occupied. Pixels that do
  // not finish a block only update memory and never wait.
  // ---------------------------------------------------------------------------
  assign out_free      = !out_valid_q || m_axis_tready;
  assign s1_adv        = s1_valid_q && (!s1_pos_q.emit || out_free);
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  bfd_position u_position (
    .clk_i,
    .rst_ni,
    .adv_i         (in_acc),
    .frame_start_i (s_axis_tuser),
    .out_width_i   (out_width_q),
    .out_height_i  (out_height_q),
    .factor_log2_i (factor_log2_q),
    .pos_o         (pos)
  );

  // ---------------------------------------------------------------------------
  // Accumulation. The memory read is issued with the transaction; the write
  // happens when the pixel leaves stage one. A pixel that reads the column
  // written at the same edge takes the freshly written sums instead.
  // ---------------------------------------------------------------------------
  assign old_sum = fwd_hit_q ? fwd_sum_q : rd_q;

  always_comb begin
    new_sum = '0;
    avg     = '0;
    for (int c = 0; c < NumChan; c++) begin
      new_sum[SumW*c +: SumW] = s1_pos_q.block_start
          ? SumW'(s1_pix_q[PixW-1-ChanW*c -: ChanW])
          : old_sum[SumW*c +: SumW] + SumW'(s1_pix_q[PixW-1-ChanW*c -: ChanW]);
      avg[PixW-1-ChanW*c -: ChanW] =
          ChanW'(new_sum[SumW*c +: SumW] >> {s1_k_q, 1'b0});
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      sum_mem[s1_pos_q.col] <= new_sum;
    end
    if (in_acc) begin
      rd_q      <= sum_mem[pos.col];
      fwd_sum_q <= new_sum;
      s1_pix_q  <= s_axis_tdata;
      s1_pos_q  <= pos;
      s1_k_q    <= factor_log2_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_hit_q  <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
        fwd_hit_q  <= s1_adv && (s1_pos_q.col == pos.col);
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
        fwd_hit_q  <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_pos_q.emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_pos_q.emit) begin
      out_pix_q       <= avg;
      out_row_end_q   <= s1_pos_q.row_end;
      out_frame_end_q <= s1_pos_q.frame_end;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_pix_q;
  assign m_axis_tlast  = out_row_end_q;
  assign m_axis_tuser  = out_frame_end_q;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  a_fwd_needs_stage : assert property (@(posedge clk_i) disable iff (!rst_ni)
      fwd_hit_q |-> s1_valid_q)
    else $error("forwarded sums without a pixel in stage one");

  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
      !s_axis_tready |-> (s1_valid_q && s1_pos_q.emit && out_valid_q))
    else $error("input stalled without a blocked finished block");

  a_frame_end_row_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
      (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
    else $error("frame end without row end");

  a_emit_loads_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
      (s1_adv && s1_pos_q.emit) |=> (out_valid_q && out_pix_q == $past(avg)))
    else $error("finished block did not reach the output register");

endmodule

`default_nettype wire

FILE: verif/bfd_checker.sv
// Checker for the box filter downsampler: predicts block means and compares them.
// Watches the pixel, result and configuration channels; depends on bfd_pkg.
`default_nettype none

module bfd_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Slave stream: tdata = subpixel[31:0]; tuser = frame_start.
  input  logic                         s_axis_tvalid,
  input  logic                         s_axis_tready,
  input  logic [bfd_pkg::PixW-1:0]     s_axis_tdata,
  input  logic                         s_axis_tuser,
  // Master stream: tdata = average_pixel[31:0]; tlast = row_end;
  // tuser = frame_end.
  input  logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  input  logic [bfd_pkg::PixW-1:0]     m_axis_tdata,
  input  logic                         m_axis_tlast,
  input  logic                         m_axis_tuser,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_o,
  input  logic [bfd_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [bfd_pkg::CfgDataW-1:0] cfg_data_i,
  output int                           pending_o,
  output int                           mismatches_o,
  output int                           means_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import bfd_pkg::*;

  localparam int unsigned PrintLimit = 20;

  typedef struct packed {
    logic [PixW-1:0] pixel;
    logic            row_end;
    logic            frame_end;
  } block_mean_t;

  block_mean_t expected_means[$];

  // Geometry registers as last written.
  logic [WidthW-1:0]  out_width;
  logic [HeightW-1:0] out_height;
  logic [FactorW-1:0] factor_log2;

  // Position counters, one bit wider than the block's so that the increment
  // past the limit is visible before it wraps.
  logic [SubW:0]      sub_col;
  logic [SubW:0]      sub_row;
  logic [ColW:0]      out_col;
  logic [RowW:0]      out_row;
  logic [SumW-1:0]    column_total [MaxOutWidth][NumChan];

  int mismatch_count;
  int mean_count;

  assign mismatches_o = mismatch_count;
  assign means_o      = mean_count;

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PrintLimit) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
    mismatch_count++;
  endtask

  // Folds one input pixel into its column sums and queues the block mean
  // when the pixel closes an FxF block.
  task automatic accumulate_pixel(input logic [PixW-1:0] px, input logic restart);
    int unsigned w;
    int unsigned h;
    int unsigned f;
    int unsigned k;
    int          c;
    logic        block_open;
    block_mean_t mean;
    k = factor_log2;
    f = 1 << k;
    w = (out_width == 0) ? 1 : ((out_width > MaxOutWidth) ? MaxOutWidth : out_width);
    h = (out_height == 0) ? 1 : ((out_height > HeightLimit) ? HeightLimit : out_height);
    if (restart) begin
      sub_col = '0;
      sub_row = '0;
      out_col = '0;
      out_row = '0;
    end
    // A geometry change can leave a counter beyond its new limit.
    if (sub_col >= f) sub_col = '0;
    if (out_col >= w) out_col = '0;
    if (sub_row >= f) sub_row = '0;
    if (out_row >= h) out_row = '0;

    block_open = (sub_row == 0) && (sub_col == 0);
    for (c = 0; c < NumChan; c++) begin
      if (block_open) begin
        column_total[out_col][c] = SumW'(px[PixW-1-ChanW*c -: ChanW]);
      end else begin
        column_total[out_col][c] = column_total[out_col][c] + px[PixW-1-ChanW*c -: ChanW];
      end
    end

    if ((sub_row + 1 == f) && (sub_col + 1 == f)) begin
      mean.pixel = '0;
      for (c = 0; c < NumChan; c++) begin
        mean.pixel[PixW-1-ChanW*c -: ChanW] = ChanW'(column_total[out_col][c] >> (2 * k));
      end
      mean.row_end   = (out_col + 1 == w);
      mean.frame_end = mean.row_end && (out_row + 1 == h);
      expected_means.push_back(mean);
    end

    sub_col++;
    if (sub_col >= f) begin
      sub_col = '0;
      out_col++;
      if (out_col >= w) begin
        out_col = '0;
        sub_row++;
        if (sub_row >= f) begin
          sub_row = '0;
          out_row++;
          if (out_row >= h) out_row = '0;
        end
      end
    end
  endtask

  task automatic compare_mean();
    block_mean_t want;
    mean_count++;
    if (expected_means.size() == 0) begin
      report_mismatch($sformatf("output pixel %08h arrived with nothing expected",
                                m_axis_tdata));
    end else begin
      want = expected_means.pop_front();
      if (m_axis_tdata !== want.pixel) begin
        report_mismatch($sformatf("average pixel %08h, expected %08h",
                                  m_axis_tdata, want.pixel));
      end
      if (m_axis_tlast !== want.row_end) begin
        report_mismatch($sformatf("row end %b, expected %b", m_axis_tlast, want.row_end));
      end
      if (m_axis_tuser !== want.frame_end) begin
        report_mismatch($sformatf("frame end %b, expected %b",
                                  m_axis_tuser, want.frame_end));
      end
    end
  endtask

  // Results are checked before the pixel of the same edge is predicted: a
  // result can never belong to a pixel taken at the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_width      = WidthW'(640);
      out_height     = HeightW'(480);
      factor_log2    = FactorW'(2);
      sub_col        = '0;
      sub_row        = '0;
      out_col        = '0;
      out_row        = '0;
      mismatch_count = 0;
      mean_count     = 0;
      expected_means.delete();
      pending_o     <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_idx_e'(cfg_addr_i))
          CfgOutWidth:   out_width   = cfg_data_i[WidthW-1:0];
          CfgOutHeight:  out_height  = cfg_data_i[HeightW-1:0];
          CfgFactorLog2: factor_log2 = cfg_data_i[FactorW-1:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) compare_mean();
      if (s_axis_tvalid && s_axis_tready) accumulate_pixel(s_axis_tdata, s_axis_tuser);
      pending_o <= expected_means.size();
    end
  end

endmodule

`default_nettype wire

FILE: verif/box_filter_downsampler_tb.sv
// Testbench top for the box filter downsampler: clock, reset, stimulus and verdict.
// Depends on bfd_pkg, box_filter_downsampler and bfd_checker.
`default_nettype none

module box_filter_downsampler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bfd_pkg::*;

  localparam realtime ClkPeriod   = 12ns;
  localparam int      ResetCycles = 5;
  // Results pass stage one and the output register; the settle wait covers that.
  localparam int      SettleCycles = 6;
  // Longest correct silence is the output hold-off below plus a sender gap.
  localparam int      HoldCycles   = 300;
  localparam int      StallLimit   = 2000;
  localparam int      RandomItems  = 250;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [PixW-1:0]     s_axis_tdata  = '0;  // subpixel[31:0]
  logic                s_axis_tuser  = 1'b0;  // frame_start
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [PixW-1:0]     m_axis_tdata;  // average_pixel[31:0]
  logic                m_axis_tlast;  // row_end
  logic                m_axis_tuser;  // frame_end
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CfgAddrW-1:0] cfg_addr_i    = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;

  int pending;
  int mismatches;
  int means;

  // Stimulus bookkeeping.
  int band_len     = 1;
  int frame_len    = 1;
  int band_pos     = 0;
  int pixels_sent  = 0;
  int frame_starts = 0;
  int settings     = 0;
  int reg_writes   = 0;
  bit idle_on      = 1'b1;
  bit hold_pending = 1'b0;
  int stall_cycles;

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  box_filter_downsampler i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_data_i   (cfg_data_i)
  );

  bfd_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_data_i   (cfg_data_i),
    .pending_o    (pending),
    .mismatches_o (mismatches),
    .means_o      (means)
  );

  // Watchdog: any transaction on any channel counts as progress.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_cycles <= 0;
    end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                 (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    wait (stall_cycles >= StallLimit);
    $display("Timeout: no transaction for %0d cycles, %0d results outstanding.",
             StallLimit, pending);
    $display("*** FAILED ***");
    $finish;
  end

  // Result side. While idle gaps are on, each result waits a random number of
  // cycles before tready rises. Once per run the receiver holds off for a long
  // stretch while the sender keeps offering pixels, so the output register fills
  // and the block has to stall its input.
  initial begin
    int gap;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_pending) begin
        hold_pending = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else begin
        gap = idle_on ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
          m_axis_tready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // Offers one pixel, after a random gap if idle_on is set, and returns at the edge
  // that takes it. tvalid stays high when the next pixel follows without a gap.
  task automatic push_pixel(input logic [PixW-1:0] px, input logic restart);
    int gap;
    gap = idle_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    s_axis_tuser  <= restart;
    do @(posedge clk_i); while (!s_axis_tready);
    // Track the place within the band so a phase can stop on a band boundary.
    if (restart) band_pos = 0;
    band_pos++;
    if (band_pos >= band_len) band_pos = 0;
    pixels_sent++;
    if (restart) frame_starts++;
  endtask

  // A run of random pixels. The first may open a new frame; with noise on,
  // an occasional frame start lands in the middle of a block or a band.
  task automatic send_run(input int count, input bit open_frame, input bit noise);
    int  i;
    logic restart;
    for (i = 0; i < count; i++) begin
      restart = (i == 0) ? open_frame : (noise && ($urandom_range(0, 63) == 0));
      push_pixel($urandom, restart);
    end
  endtask

  // Registers may only change while nothing is in flight.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    reg_writes++;
  endtask

  // Writes all three geometry registers. A setting either opens with a frame
  // start or follows a band boundary, so no column sum is read before the
  // current band has written it.
  task automatic set_geometry(input int w, input int h, input int k);
    int w_eff;
    int h_eff;
    wait_idle();
    write_reg(CfgOutWidth, CfgDataW'(w));
    write_reg(CfgOutHeight, CfgDataW'(h));
    write_reg(CfgFactorLog2, CfgDataW'(k));
    cfg_valid_i <= 1'b0;
    w_eff = (w == 0) ? 1 : ((w > MaxOutWidth) ? MaxOutWidth : w);
    h_eff = (h == 0) ? 1 : ((h > HeightLimit) ? HeightLimit : h);
    band_len  = w_eff << (2 * k);
    frame_len = band_len * h_eff;
    settings++;
  endtask

  initial begin
    int i;
    int k;
    int w;
    int h;
    int frames;
    int random_base;
    bit follow_on;

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // 1x1 blocks on a 2x2 image: every pixel comes straight back, so the
    // extreme pixel values and both flags are easy to see. The second frame
    // is cut short by a frame start in the middle of its first row.
    set_geometry(2, 2, 0);
    push_pixel(32'h0000_0000, 1'b1);
    push_pixel(32'hFFFF_FFFF, 1'b0);
    push_pixel(32'h1234_5678, 1'b0);
    push_pixel(32'h80FF_007F, 1'b0);
    push_pixel(32'hDEAD_BEEF, 1'b1);
    push_pixel(32'hA5A5_A5A5, 1'b1);
    push_pixel(32'h5A5A_5A5A, 1'b0);
    push_pixel(32'h0102_0304, 1'b0);
    push_pixel(32'hFEDC_BA98, 1'b0);

    // 2x2 blocks on a 1x1 image: a full-scale block, then one whose mean is
    // truncated to zero, then a frame that wraps without a frame start.
    set_geometry(1, 1, 1);
    for (i = 0; i < 4; i++) push_pixel(32'hFFFF_FFFF, i == 0);
    for (i = 0; i < 3; i++) push_pixel(32'h0101_0101, 1'b0);
    push_pixel(32'h0000_0000, 1'b0);
    send_run(4, 1'b0, 1'b0);

    // Largest factor with width and height of zero, which act as one.
    set_geometry(0, 0, MaxFactorLog2);
    for (i = 0; i < 64; i++) push_pixel(32'hFFFF_FFFF, i == 0);
    send_run(64, 1'b0, 1'b0);

    // Full width and an oversized height: one band touches every column.
    set_geometry(MaxOutWidth, 8191, 0);
    send_run(MaxOutWidth, 1'b1, 1'b0);

    // Height drops below the row counter in the middle of the frame, so the
    // counter clears. The width is oversized and acts as the maximum.
    set_geometry(2047, 1, 0);
    send_run(20, 1'b0, 1'b0);

    set_geometry(1, HeightLimit, 0);
    send_run(10, 1'b1, 1'b0);
    set_geometry(3, 3, 1);
    send_run(72, 1'b0, 1'b0);

    // Back-pressure: the sender runs flat out while the receiver holds off.
    set_geometry(4, 4, 0);
    idle_on = 1'b0;
    hold_pending = 1'b1;
    send_run(64, 1'b1, 1'b0);

    // Random part: mostly whole frames on small images with random content,
    // with stray frame starts and partial frames mixed in.
    random_base = pixels_sent;
    while (pixels_sent - random_base < RandomItems) begin
      follow_on = $urandom_range(0, 1);
      if (follow_on) begin
        while (band_pos != 0) push_pixel($urandom, 1'b0);
      end
      k = $urandom_range(0, MaxFactorLog2);
      case (k)
        3: begin
          w = $urandom_range(0, 3);
          h = $urandom_range(0, 2);
        end
        2: begin
          w = $urandom_range(0, 8);
          h = $urandom_range(0, 3);
        end
        default: begin
          w = $urandom_range(0, 12);
          h = $urandom_range(0, 4);
        end
      endcase
      set_geometry(w, h, k);
      idle_on = ($urandom_range(0, 3) != 0);
      frames = (frame_len > 200) ? 1 : $urandom_range(1, 3);
      send_run(frames * frame_len, !follow_on, 1'b1);
      if ($urandom_range(0, 3) == 0) send_run($urandom_range(1, band_len), 1'b0, 1'b1);
    end

    wait_idle();

    $display("Coverage: %0d pixels (%0d with frame start) under %0d geometry settings,",
             pixels_sent, frame_starts, settings);
    $display("  %0d register writes, %0d block means compared, one %0d-cycle output hold-off.",
             reg_writes, means, HoldCycles);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches.", mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: files.f
src/bfd_pkg.sv
src/bfd_position.sv
src/box_filter_downsampler.sv
verif/bfd_checker.sv
verif/box_filter_downsampler_tb.sv
